[hw/rtl/itpfr_pkg.sv]
package itpfr_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int FUNC_W = 2;
    localparam int DATA_W = 8;
    localparam int IDX_W = 6;
    localparam int EV_W = 3;
    localparam int LEN_W = 7;
    localparam int TMO_W = 16;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [FUNC_W-1:0] {
        FN_BYTE    = 2'd0,
        FN_TICK    = 2'd1,
        FN_RELEASE = 2'd2,
        FN_READ    = 2'd3
    } t_func;

    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 3'd0,
        EV_FRAME     = 3'd1,
        EV_DROP_FULL = 3'd2,
        EV_RX_ERR    = 3'd3,
        EV_DROP_OFF  = 3'd4,
        EV_READ      = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        FILL_IDLE   = 3'b001,
        FILL_FIRST  = 3'b010,
        FILL_SECOND = 3'b100
    } t_fill;

    typedef struct packed {
        t_func              func;
        logic [DATA_W-1:0]  rx_byte;
        logic               rx_error;
        logic               buffer_select;
        logic [IDX_W-1:0]   read_index;
    } t_item;

    typedef struct packed {
        t_event             ev;
        logic               frame_buffer;
        logic [LEN_W-1:0]   frame_length;
        logic [1:0]         valid_mask;
        logic               busy;
        logic               rd_hit;
    } t_result;

endpackage

[hw/rtl/itpfr_if.sv]
interface itpfr_in_if
    import itpfr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] rx_byte;
    logic              rx_error;
    logic              buffer_select;
    logic [IDX_W-1:0]  read_index;

    modport source (
        output valid, func, rx_byte, rx_error, buffer_select, read_index,
        input  ready
    );
    modport sink (
        input  valid, func, rx_byte, rx_error, buffer_select, read_index,
        output ready
    );
endinterface

interface itpfr_out_if
    import itpfr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [EV_W-1:0]   event_res;
    logic              frame_buffer;
    logic [LEN_W-1:0]  frame_length;
    logic [DATA_W-1:0] read_data;
    logic [1:0]        valid_mask;
    logic              busy_res;

    modport source (
        output valid, event_res, frame_buffer, frame_length, read_data, valid_mask,
               busy_res,
        input  ready
    );
    modport sink (
        input  valid, event_res, frame_buffer, frame_length, read_data, valid_mask,
               busy_res,
        output ready
    );
endinterface

[hw/rtl/itpfr_ram.sv]
module itpfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/itpfr_ctrl.sv]
module itpfr_ctrl
    import itpfr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int AW = $clog2(2 * FRAME_BYTES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_item             i_item,
    input  logic [TMO_W-1:0]  i_timeout,
    output t_result           o_res,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [DATA_W-1:0] o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr
);

    localparam int CW = (FRAME_BYTES > 2) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [CW-1:0] LAST_POS = CW'(FRAME_BYTES - 1);
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(FRAME_BYTES);
    localparam logic [AW-1:0] BUF1_BASE = AW'(FRAME_BYTES);

    t_fill             r_fill, n_fill;
    logic [1:0]        r_valid, n_valid;
    logic [LEN_W-1:0]  r_len [2];
    logic [LEN_W-1:0]  n_len [2];
    logic [CW-1:0]     r_count, n_count;
    logic [TMO_W-1:0]  r_idle, n_idle;
    logic              r_run, n_run;
    logic              r_off, n_off;

    logic              commit_en;
    logic              commit_buf;
    logic [LEN_W-1:0]  commit_len;
    logic              cur_buf;
    logic [TMO_W-1:0]  idle_inc;

    assign cur_buf  = (r_fill == FILL_SECOND);
    assign idle_inc = r_idle + TMO_W'(1);

    always_comb begin
        n_fill     = r_fill;
        n_valid    = r_valid;
        n_len      = r_len;
        n_count    = r_count;
        n_idle     = r_idle;
        n_run      = r_run;
        n_off      = r_off;
        commit_en  = 1'b0;
        commit_buf = 1'b0;
        commit_len = '0;
        o_res      = '0;
        o_res.ev   = EV_NONE;
        o_wr_en    = 1'b0;
        o_wr_addr  = '0;
        o_wr_data  = i_item.rx_byte;
        o_rd_en    = 1'b0;
        o_rd_addr  = AW'(i_item.read_index) + (i_item.buffer_select ? BUF1_BASE : '0);

        if (i_step) begin
            unique case (i_item.func)
                FN_BYTE: begin
                    if (r_off) begin
                        o_res.ev = EV_DROP_OFF;
                    end else begin
                        n_idle = '0;
                        n_run  = 1'b1;
                        if (i_item.rx_error) begin
                            n_fill   = FILL_IDLE;
                            n_count  = '0;
                            o_res.ev = EV_RX_ERR;
                        end else begin
                            unique case (r_fill)
                                FILL_IDLE: begin
                                    if (!r_valid[0]) begin
                                        o_wr_en   = 1'b1;
                                        o_wr_addr = '0;
                                        n_fill    = FILL_FIRST;
                                        n_count   = CW'(1);
                                    end else if (!r_valid[1]) begin
                                        o_wr_en   = 1'b1;
                                        o_wr_addr = BUF1_BASE;
                                        n_fill    = FILL_SECOND;
                                        n_count   = CW'(1);
                                    end else begin
                                        n_count  = '0;
                                        o_res.ev = EV_DROP_FULL;
                                    end
                                end
                                FILL_FIRST, FILL_SECOND: begin
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = AW'(r_count) + (cur_buf ? BUF1_BASE : '0);
                                    if (r_count == LAST_POS) begin
                                        commit_en  = 1'b1;
                                        commit_buf = cur_buf;
                                        commit_len = FULL_LEN;
                                    end else begin
                                        n_count = r_count + CW'(1);
                                    end
                                end
                                default: begin
                                    n_fill  = FILL_IDLE;
                                    n_count = '0;
                                end
                            endcase
                        end
                    end
                end
                FN_TICK: begin
                    if (r_run) begin
                        n_idle = idle_inc;
                        if (idle_inc >= i_timeout) begin
                            if (r_fill != FILL_IDLE && r_count != '0) begin
                                commit_en  = 1'b1;
                                commit_buf = cur_buf;
                                commit_len = LEN_W'(r_count);
                            end else begin
                                n_run   = 1'b0;
                                n_idle  = '0;
                                n_fill  = FILL_IDLE;
                                n_count = '0;
                            end
                        end
                    end
                end
                FN_RELEASE: begin
                    n_valid[i_item.buffer_select] = 1'b0;
                    n_off = 1'b0;
                end
                FN_READ: begin
                    o_res.ev           = EV_READ;
                    o_res.frame_buffer = i_item.buffer_select;
                    o_res.frame_length = r_len[i_item.buffer_select];
                    if (32'(i_item.read_index) < FRAME_BYTES) begin
                        o_rd_en      = 1'b1;
                        o_res.rd_hit = 1'b1;
                    end
                end
                default: begin
                    o_res.ev = EV_NONE;
                end
            endcase

            if (commit_en) begin
                n_valid[commit_buf] = 1'b1;
                n_len[commit_buf]   = commit_len;
                n_off               = 1'b1;
                n_run               = 1'b0;
                n_idle              = '0;
                n_fill              = FILL_IDLE;
                n_count             = '0;
                o_res.ev            = EV_FRAME;
                o_res.frame_buffer  = commit_buf;
                o_res.frame_length  = commit_len;
            end
        end

        o_res.valid_mask = n_valid;
        o_res.busy       = n_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= FILL_IDLE;
            r_valid  <= '0;
            r_len[0] <= '0;
            r_len[1] <= '0;
            r_count  <= '0;
            r_idle   <= '0;
            r_run    <= 1'b0;
            r_off    <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_valid  <= n_valid;
            r_len[0] <= n_len[0];
            r_len[1] <= n_len[1];
            r_count  <= n_count;
            r_idle   <= n_idle;
            r_run    <= n_run;
            r_off    <= n_off;
        end
    end

endmodule

[hw/rtl/idle_timeout_pingpong_frame_receiver.sv]
// Channel   Direction  Payload
// i_in      sink       func, rx_byte, rx_error, buffer_select, read_index
// o_out     source     event_res, frame_buffer, frame_length, read_data, valid_mask, busy_res
// i_cfg     write      idle_timeout_ticks (16 bits, no read-back)
//
// One transaction per cycle unless the output stalls; item and result are each registered.
// The rate is set by the single pass through the control logic and the frame buffer port.
// Reset is synchronous and active low; the frame buffer is not cleared.
// A stalled output holds its result while one more input transaction is accepted.
module idle_timeout_pingpong_frame_receiver
    import itpfr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    itpfr_in_if.sink         i_in,
    itpfr_out_if.source      o_out,
    input  logic             i_cfg_wr_en,
    input  logic [TMO_W-1:0] i_cfg_wr_data
);

    localparam int AW = $clog2(2 * FRAME_BYTES);

    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    t_result           r_res;
    logic [TMO_W-1:0]  r_timeout;

    logic              advance;
    logic              step;
    t_result           res;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    assign advance    = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= step;
            end
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.func          <= t_func'(i_in.func);
            r_item.rx_byte       <= i_in.rx_byte;
            r_item.rx_error      <= i_in.rx_error;
            r_item.buffer_select <= i_in.buffer_select;
            r_item.read_index    <= i_in.read_index;
        end
        if (step) begin
            r_res <= res;
        end
    end

    itpfr_ctrl #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_item),
        .i_timeout (r_timeout),
        .o_res     (res),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    itpfr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2 * FRAME_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_res.ev;
    assign o_out.frame_buffer = r_res.frame_buffer;
    assign o_out.frame_length = r_res.frame_length;
    assign o_out.read_data    = r_res.rd_hit ? rd_data : '0;
    assign o_out.valid_mask   = r_res.valid_mask;
    assign o_out.busy_res     = r_res.busy;

endmodule
